// ===== design/hsl2rgb_pkg.sv =====
// Package for the HSL to RGB colour converter: beat types and constants shared
// by the datapath and its checker, and the datapath's reciprocal multipliers.
// Depends on nothing.
package hsl2rgb_pkg;

  // Fraction width of the internal fixed-point values; ONE needs one bit more.
  localparam int FRAC_BITS = 16;
  localparam int FX_W      = FRAC_BITS + 1;

  localparam logic [FX_W-1:0] FX_ONE   = FX_W'(1 << FRAC_BITS);
  localparam logic [FX_W-1:0] FX_HALF  = FX_W'(1 << (FRAC_BITS - 1));
  localparam logic [FX_W-1:0] FX_THIRD = FX_W'((1 << FRAC_BITS) / 3);
  localparam logic [FX_W-1:0] FX_TWO3  = FX_W'(2 * ((1 << FRAC_BITS) / 3));

  localparam logic [14:0] HUE_FULL = 15'd23040;
  localparam logic [6:0]  PCT_MAX  = 7'd100;

  // hue * 2^F / 23040 = hue * 2^(F-9) / 45; 2^30/45 rounded up is exact
  // for every hue in range, so the quotient is the product shifted down.
  localparam logic [24:0] HUE_RECIP = 25'd23860930;
  localparam int          HUE_SHIFT = 30 + 9 - FRAC_BITS;

  // pct * 2^F / 100 = pct * 2^(F-2) / 25; 2^30/25 rounded up, exact here.
  localparam logic [25:0] PCT_RECIP = 26'd42949673;
  localparam int          PCT_SHIFT = 32 - FRAC_BITS;

  // floor(n / 100) = floor((n >> 2) / 25); 2^20/25 rounded up, exact for n >> 2 < 2^13.
  localparam logic [15:0] BYTE_RECIP = 16'd41944;
  localparam int          BYTE_SHIFT = 20;

  // Cycles from an accepted start to its result strobe.
  localparam int LATENCY = 6;

  typedef struct packed {
    logic [14:0] hue;
    logic [6:0]  saturation;
    logic [6:0]  lightness;
  } hsl_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

// ===== design/hsl_to_rgb_converter.sv =====
// HSL to RGB colour converter: six-stage pipeline, one colour per beat.
// Depends on hsl2rgb_pkg for the beat types and fixed-point constants.
//
//   channel  | handshake         | payload              | direction
//   ---------+-------------------+----------------------+----------
//   request  | start, busy       | hsl_i (hsl_t)        | in
//   result   | done_o (strobe)   | rgb_o (rgb_t)        | out
//
// A colour is taken on every clock edge with start high; busy is held low, as
// every stage advances on every cycle. Each result appears on rgb_o with done_o
// high for exactly one cycle, once its request has passed the six register
// stages: scale, q, ramp select, ramp multiply, percent, byte.
// Reset clears only the valid bits travelling with the beats; payload registers
// are not reset and load when their stage's valid bit is set. The receiver cannot stall, so nothing is ever held.
module hsl_to_rgb_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  hsl2rgb_pkg::hsl_t  hsl_i,
  output logic               done_o,
  output hsl2rgb_pkg::rgb_t  rgb_o
);

  localparam int FB = hsl2rgb_pkg::FRAC_BITS;
  localparam int FW = hsl2rgb_pkg::FX_W;

  // Which piece of the hue ramp a channel sits on.
  typedef enum logic [1:0] {
    SEG_RAMP,   // rising or falling edge: p + d * m
    SEG_HIGH,   // plateau at q
    SEG_LOW     // floor at p
  } seg_e;

  // Valid bits, one per stage.
  logic [hsl2rgb_pkg::LATENCY-1:0] vld_d, vld_q;

  assign busy  = 1'b0;
  assign vld_d = {vld_q[hsl2rgb_pkg::LATENCY-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: wrap and saturate the inputs, scale them to fractions.
  // ---------------------------------------------------------------------------
  logic [14:0]   hue_w;
  logic [6:0]    sat_c, lig_c;
  logic [39:0]   hue_prod;
  logic [32:0]   sat_prod, lig_prod;
  logic [FB-1:0] s1_h_d, s1_h_q;
  logic [FW-1:0] s1_s_d, s1_s_q, s1_l_d, s1_l_q;
  logic          s1_grey_q;
  logic [6:0]    s1_lig_q;

  always_comb begin
    hue_w    = (hsl_i.hue >= hsl2rgb_pkg::HUE_FULL) ? hsl_i.hue - hsl2rgb_pkg::HUE_FULL
                                                    : hsl_i.hue;
    sat_c    = (hsl_i.saturation > hsl2rgb_pkg::PCT_MAX) ? hsl2rgb_pkg::PCT_MAX
                                                         : hsl_i.saturation;
    lig_c    = (hsl_i.lightness > hsl2rgb_pkg::PCT_MAX) ? hsl2rgb_pkg::PCT_MAX
                                                        : hsl_i.lightness;
    hue_prod = 40'(hue_w) * 40'(hsl2rgb_pkg::HUE_RECIP);
    sat_prod = 33'(sat_c) * 33'(hsl2rgb_pkg::PCT_RECIP);
    lig_prod = 33'(lig_c) * 33'(hsl2rgb_pkg::PCT_RECIP);
    s1_h_d   = hue_prod[hsl2rgb_pkg::HUE_SHIFT +: FB];
    s1_s_d   = sat_prod[hsl2rgb_pkg::PCT_SHIFT +: FW];
    s1_l_d   = lig_prod[hsl2rgb_pkg::PCT_SHIFT +: FW];
  end

  always_ff @(posedge clk_i) begin
    if (vld_d[0]) begin
      s1_h_q    <= s1_h_d;
      s1_s_q    <= s1_s_d;
      s1_l_q    <= s1_l_d;
      s1_grey_q <= (sat_c == '0);
      s1_lig_q  <= lig_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: form q and the three channel hues (offsets wrap modulo ONE).
  // ---------------------------------------------------------------------------
  logic              low_l;
  logic [FW:0]       mul_b;
  logic [2*FW:0]     q_prod;
  logic [FW+1:0]     q_raw;
  logic [FW-1:0]     s2_q_d, s2_q_q, s2_l_q;
  logic [2:0][FB-1:0] s2_t_d, s2_t_q;
  logic              s2_grey_q;
  logic [6:0]        s2_lig_q;

  always_comb begin
    low_l  = (s1_l_q < hsl2rgb_pkg::FX_HALF);
    mul_b  = low_l ? (FW+1)'(hsl2rgb_pkg::FX_ONE) + (FW+1)'(s1_s_q) : (FW+1)'(s1_s_q);
    q_prod = (2*FW+1)'(s1_l_q) * (2*FW+1)'(mul_b);
    if (low_l) begin
      q_raw = q_prod[FB +: FW+2];
    end else begin
      q_raw = (FW+2)'(s1_l_q) + (FW+2)'(s1_s_q) - q_prod[FB +: FW+2];
    end
    s2_q_d = (q_raw > (FW+2)'(hsl2rgb_pkg::FX_ONE)) ? hsl2rgb_pkg::FX_ONE : q_raw[FW-1:0];
    s2_t_d[0] = s1_h_q + hsl2rgb_pkg::FX_THIRD[FB-1:0];
    s2_t_d[1] = s1_h_q;
    s2_t_d[2] = s1_h_q - hsl2rgb_pkg::FX_THIRD[FB-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[0]) begin
      s2_q_q    <= s2_q_d;
      s2_l_q    <= s1_l_q;
      s2_t_q    <= s2_t_d;
      s2_grey_q <= s1_grey_q;
      s2_lig_q  <= s1_lig_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: form p and the span d, pick each channel's ramp piece and slope.
  // ---------------------------------------------------------------------------
  logic [FW:0]        two_l;
  logic [FW:0]        p_raw;
  logic [FW-1:0]      s3_p_d, s3_p_q, s3_d_d, s3_d_q, s3_q_q;
  logic [FB+2:0]      t6 [3];
  logic [FB+1:0]      t3 [3];
  logic [FB-1:0]      w  [3];
  logic [FB+2:0]      w6 [3];
  seg_e               s3_seg_d [3];
  seg_e               s3_seg_q [3];
  logic [2:0][FB-1:0] s3_m_d, s3_m_q;
  logic               s3_grey_q;
  logic [6:0]         s3_lig_q;

  always_comb begin
    two_l  = {s2_l_q, 1'b0};
    p_raw  = (two_l > (FW+1)'(s2_q_q)) ? two_l - (FW+1)'(s2_q_q) : '0;
    s3_p_d = (p_raw > (FW+1)'(hsl2rgb_pkg::FX_ONE)) ? hsl2rgb_pkg::FX_ONE : p_raw[FW-1:0];
    s3_d_d = (s2_q_q > s3_p_d) ? s2_q_q - s3_p_d : '0;
    for (int c = 0; c < 3; c++) begin
      t6[c] = ((FB+3)'(s2_t_q[c]) << 2) + ((FB+3)'(s2_t_q[c]) << 1);
      t3[c] = ((FB+2)'(s2_t_q[c]) << 1) + (FB+2)'(s2_t_q[c]);
      w[c]  = ((FW)'(s2_t_q[c]) < hsl2rgb_pkg::FX_TWO3)
            ? hsl2rgb_pkg::FX_TWO3[FB-1:0] - s2_t_q[c] : '0;
      w6[c] = ((FB+3)'(w[c]) << 2) + ((FB+3)'(w[c]) << 1);
      priority if (t6[c] < (FB+3)'(hsl2rgb_pkg::FX_ONE)) begin
        s3_seg_d[c] = SEG_RAMP;
        s3_m_d[c]   = t6[c][FB-1:0];
      end else if ((FW)'(s2_t_q[c]) < hsl2rgb_pkg::FX_HALF) begin
        s3_seg_d[c] = SEG_HIGH;
        s3_m_d[c]   = '0;
      end else if (t3[c] < ((FB+2)'(hsl2rgb_pkg::FX_ONE) << 1)) begin
        s3_seg_d[c] = SEG_RAMP;
        s3_m_d[c]   = w6[c][FB-1:0];
      end else begin
        s3_seg_d[c] = SEG_LOW;
        s3_m_d[c]   = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[1]) begin
      s3_p_q    <= s3_p_d;
      s3_d_q    <= s3_d_d;
      s3_q_q    <= s2_q_q;
      s3_seg_q  <= s3_seg_d;
      s3_m_q    <= s3_m_d;
      s3_grey_q <= s2_grey_q;
      s3_lig_q  <= s2_lig_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: evaluate the ramp, one multiplier per channel.
  // ---------------------------------------------------------------------------
  logic [FW+FB-1:0]   ramp_prod [3];
  logic [FW:0]        v_ramp    [3];
  logic [2:0][FW-1:0] s4_v_d, s4_v_q;
  logic               s4_grey_q;
  logic [6:0]         s4_lig_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ramp_prod[c] = (FW+FB)'(s3_d_q) * (FW+FB)'(s3_m_q[c]);
      v_ramp[c]    = (FW+1)'(s3_p_q) + (FW+1)'(ramp_prod[c][FB +: FW]);
      unique case (s3_seg_q[c])
        SEG_RAMP: s4_v_d[c] = (v_ramp[c] > (FW+1)'(hsl2rgb_pkg::FX_ONE))
                            ? hsl2rgb_pkg::FX_ONE : v_ramp[c][FW-1:0];
        SEG_HIGH: s4_v_d[c] = s3_q_q;
        SEG_LOW:  s4_v_d[c] = s3_p_q;
        default:  s4_v_d[c] = s3_p_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[2]) begin
      s4_v_q    <= s4_v_d;
      s4_grey_q <= s3_grey_q;
      s4_lig_q  <= s3_lig_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: truncate to whole percent; grey takes the lightness percent.
  // ---------------------------------------------------------------------------
  logic [FW+6:0]     pct_prod [3];
  logic [FW+6-FB:0]  pct_w    [3];
  logic [2:0][6:0]   s5_pct_d, s5_pct_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pct_prod[c] = (FW+7)'(s4_v_q[c]) * (FW+7)'(hsl2rgb_pkg::PCT_MAX);
      pct_w[c]    = pct_prod[c][FW+6:FB];
      if (s4_grey_q) begin
        s5_pct_d[c] = s4_lig_q;
      end else if (pct_w[c] > (FW+7-FB)'(hsl2rgb_pkg::PCT_MAX)) begin
        s5_pct_d[c] = hsl2rgb_pkg::PCT_MAX;
      end else begin
        s5_pct_d[c] = pct_w[c][6:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[3]) begin
      s5_pct_q <= s5_pct_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: byte = (pct * 255 + 50) / 100, division by reciprocal.
  // ---------------------------------------------------------------------------
  logic [14:0]      byte_n    [3];
  logic [28:0]      byte_prod [3];
  logic [2:0][7:0]  byte_d;
  hsl2rgb_pkg::rgb_t rgb_d, rgb_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      byte_n[c]    = (15'(s5_pct_q[c]) << 8) - 15'(s5_pct_q[c]) + 15'd50;
      byte_prod[c] = 29'(byte_n[c][14:2]) * 29'(hsl2rgb_pkg::BYTE_RECIP);
      byte_d[c]    = byte_prod[c][hsl2rgb_pkg::BYTE_SHIFT +: 8];
    end
    rgb_d.red   = byte_d[0];
    rgb_d.green = byte_d[1];
    rgb_d.blue  = byte_d[2];
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[4]) begin
      rgb_q <= rgb_d;
    end
  end

  assign done_o = vld_q[hsl2rgb_pkg::LATENCY-1];
  assign rgb_o  = rgb_q;

endmodule

// ===== design/hsl2rgb_chk.sv =====
// Port-level checker for the HSL to RGB colour converter, bound to the top level.
// Depends on hsl2rgb_pkg for the beat types and the pipeline latency.
module hsl2rgb_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input hsl2rgb_pkg::hsl_t hsl_i,
  input logic              done_o,
  input hsl2rgb_pkg::rgb_t rgb_o
);

  // Every accepted beat is followed by its result strobe.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(hsl2rgb_pkg::LATENCY) done_o)
    else $error("result strobe missing after accepted beat");

  // No strobe without a matching accepted beat.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, hsl2rgb_pkg::LATENCY))
    else $error("result strobe without matching request");

  // Zero saturation yields a grey.
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start && !busy && hsl_i.saturation == '0, hsl2rgb_pkg::LATENCY))
    |-> (rgb_o.red == rgb_o.green && rgb_o.green == rgb_o.blue))
    else $error("grey input gave unequal channels");

  // Zero lightness yields black.
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start && !busy && hsl_i.lightness == '0, hsl2rgb_pkg::LATENCY))
    |-> (rgb_o == '0))
    else $error("zero lightness did not give black");

  // Full lightness yields white.
  a_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start && !busy && hsl_i.lightness >= hsl2rgb_pkg::PCT_MAX,
                     hsl2rgb_pkg::LATENCY))
    |-> (rgb_o.red == 8'hFF && rgb_o.green == 8'hFF && rgb_o.blue == 8'hFF))
    else $error("full lightness did not give white");

endmodule

bind hsl_to_rgb_converter hsl2rgb_chk u_hsl2rgb_chk (.*);
